// File: rtl/core/grid_region_allocator_macros.svh
// Assertion macros for the grid region allocator.
// Used by files that assert; relies on clk and arst_n in the including scope.
`ifndef GRID_REGION_ALLOCATOR_MACROS_SVH
`define GRID_REGION_ALLOCATOR_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define GAR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition leads to a consequence in the cycle after.
`define GAR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

// File: rtl/core/gar_pkg.sv
// Shared types and constants for the grid region allocator.
// No dependencies.
package gar_pkg;

	localparam int DEF_MAX_COLUMNS = 16;
	localparam int DEF_MAX_ROWS    = 16;

	// Width of coordinate sums; holds 64 + 31 with room to spare.
	localparam int CMP_W = 8;

	localparam logic [4:0] COLS_RESET = 5'd8;
	localparam logic [4:0] ROWS_RESET = 5'd8;

	localparam logic CFG_COLS = 1'b0;
	localparam logic CFG_ROWS = 1'b1;

	typedef enum logic [1:0] {
		OP_PLACE  = 2'd0,
		OP_REMOVE = 2'd1,
		OP_MOVE   = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_SIZE  = 3'd1,
		ST_NO_ROOM   = 3'd2,
		ST_OCCUPIED  = 3'd3,
		ST_TILE_FREE = 3'd4
	} status_t;

endpackage

// File: rtl/core/gar_if.sv
// Channel interfaces for the grid region allocator: request, response, config.
// Depends on nothing.
interface gar_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] item_id;
	logic [4:0] item_width;
	logic [4:0] item_height;
	logic [3:0] target_col;
	logic [3:0] target_row;
	modport source (output valid, opcode, item_id, item_width, item_height, target_col,
		target_row, input ready);
	modport sink (input valid, opcode, item_id, item_width, item_height, target_col,
		target_row, output ready);
endinterface

interface gar_rsp_if;
	logic       valid;
	logic       ready;
	logic       success;
	logic [2:0] status;
	logic [7:0] control_index;
	logic [7:0] freed_owner;
	modport source (output valid, success, status, control_index, freed_owner, input ready);
	modport sink (input valid, success, status, control_index, freed_owner, output ready);
endinterface

interface gar_cfg_if;
	logic       valid;
	logic       ready;
	logic       reg_index;
	logic [4:0] wdata;
	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

// File: rtl/core/gar_tile_ram.sv
// Owner store of the grid region allocator: one write port, one read port.
// Read data is registered. Depends on nothing.
module gar_tile_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: rtl/core/grid_region_allocator.sv
// First-fit rectangle allocator over a tile owner grid (top level).
// Depends on gar_pkg, gar_if, gar_tile_ram and grid_region_allocator_macros.svh.
//
//  channel | dir | beat carries
//  --------+-----+------------------------------------------------------------
//  req     | in  | opcode, item_id, item_width, item_height, target_col/row
//  rsp     | out | success, status, control_index, freed_owner
//  cfg     | in  | reg_index (0 columns, 1 rows), wdata
//
// One request at a time. A place tries each corner in turn, reads the tiles of its
// rectangle through the store's single read port, then claims the w*h tiles; a
// remove that finds an owner and a move that fits sweep all MAX_ROWS*MAX_COLUMNS
// entries once (one per cycle). After reset a clearing pass writes zero to all
// MAX_ROWS*MAX_COLUMNS entries, one a cycle, before the first request is taken.
// A request may be taken while the previous response still waits on rsp.
`include "grid_region_allocator_macros.svh"

module grid_region_allocator #(
	parameter int MAX_COLUMNS = gar_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_ROWS    = gar_pkg::DEF_MAX_ROWS
) (
	input logic   clk,
	input logic   arst_n,
	gar_req_if.sink   req,
	gar_rsp_if.source rsp,
	gar_cfg_if.sink   cfg
);
	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(MAX_COLUMNS);
	localparam int YW    = $clog2(MAX_ROWS);
	localparam int CW    = gar_pkg::CMP_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_COLUMNS);
	localparam logic [CW-1:0] MAXR = CW'(MAX_ROWS);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CORNER, S_ADV, S_RD, S_EV, S_CLAIM,
		S_RM_RD, S_RM_EV, S_SWEEP, S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [4:0] cols_cfg_q, rows_cfg_q;
	logic [CW-1:0] cols_eff, rows_eff;

	// request context
	gar_pkg::opcode_t op_q;
	logic [7:0] id_q, keep_q, owner_q;
	logic [4:0] w_q, h_q;
	logic [3:0] tc_q, tr_q;
	logic [CW-1:0] cols_q, rows_q;
	logic [XW-1:0] cx_q;
	logic [YW-1:0] cy_q;
	logic [4:0] dx_q, dy_q;

	// sweep and clear
	logic [AW-1:0] clr_q, sw_q, addr_s1;
	logic          sw_run_q, pend_s1;

	// result
	logic             res_ok_q;
	gar_pkg::status_t res_st_q;
	logic [7:0]       res_cidx_q, res_freed_q;
	logic             out_vld_q, out_ok_q;
	logic [2:0]       out_st_q;
	logic [7:0]       out_cidx_q, out_freed_q;

	// store ports
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;

	// rectangle tile under test or claim
	logic [CW-1:0] tx_sum, ty_sum;
	logic [AW-1:0] rect_addr, rm_addr;
	logic [CW-1:0] cx_next;
	logic          dx_last, dy_last, tile_bad;
	logic [15:0]   cidx_full;

	// request-side checks on the live beat
	logic [CW-1:0] req_cols, req_rows;
	logic          req_size_bad, req_mv_fit, req_rm_in;

	function automatic logic [CW-1:0] clamp_dim(input logic [4:0] v, input logic [CW-1:0] mx);
		logic [CW-1:0] ve;
		ve = CW'(v);
		if (ve == '0) begin
			return CW'(1);
		end
		if (ve > mx) begin
			return mx;
		end
		return ve;
	endfunction

	assign cols_eff = clamp_dim(cols_cfg_q, MAXC);
	assign rows_eff = clamp_dim(rows_cfg_q, MAXR);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_cfg_q <= gar_pkg::COLS_RESET;
			rows_cfg_q <= gar_pkg::ROWS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				gar_pkg::CFG_COLS: cols_cfg_q <= cfg.wdata;
				gar_pkg::CFG_ROWS: rows_cfg_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// Tile addressing: row-major over the full MAX_COLUMNS pitch.
	assign tx_sum    = CW'(cx_q) + CW'(dx_q);
	assign ty_sum    = CW'(cy_q) + CW'(dy_q);
	assign rect_addr = AW'(ty_sum[YW-1:0]) * AW'(MAX_COLUMNS) + AW'(tx_sum[XW-1:0]);
	assign rm_addr   = AW'(tr_q) * AW'(MAX_COLUMNS) + AW'(tc_q);
	assign cx_next   = CW'(cx_q) + CW'(1);
	assign dx_last   = (dx_q + 5'd1) == w_q;
	assign dy_last   = (dy_q + 5'd1) == h_q;
	assign tile_bad  = (ram_rdata != 8'd0) && (ram_rdata != keep_q);
	assign cidx_full = 16'(cy_q) * 16'(cols_q) + 16'(cx_q);

	assign req_cols     = cols_eff;
	assign req_rows     = rows_eff;
	assign req_size_bad = (req.item_width == 5'd0) || (req.item_height == 5'd0) ||
		(req.item_id == 8'd0);
	assign req_mv_fit   = (CW'(req.target_col) + CW'(req.item_width) <= req_cols) &&
		(CW'(req.target_row) + CW'(req.item_height) <= req_rows);
	assign req_rm_in    = (CW'(req.target_col) < req_cols) && (CW'(req.target_row) < req_rows);

	assign req.ready = (state_q == S_IDLE);

	// Store port steering.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rect_addr;
		ram_wdata = id_q;
		ram_re    = 1'b0;
		ram_raddr = rect_addr;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = 8'd0;
			end
			S_RD: begin
				ram_re = 1'b1;
			end
			S_RM_RD: begin
				ram_re    = 1'b1;
				ram_raddr = rm_addr;
			end
			S_SWEEP: begin
				ram_re    = sw_run_q;
				ram_raddr = sw_q;
				ram_we    = pend_s1 && (ram_rdata == owner_q);
				ram_waddr = addr_s1;
				ram_wdata = 8'd0;
			end
			S_CLAIM: begin
				ram_we = 1'b1;
			end
			default: ;
		endcase
	end

	gar_tile_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			sw_run_q  <= 1'b0;
			pend_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			// drop the beat once taken, unless a new one is loaded below
			if (rsp.ready && (state_q != S_DONE)) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						op_q        <= gar_pkg::opcode_t'(req.opcode);
						id_q        <= req.item_id;
						w_q         <= req.item_width;
						h_q         <= req.item_height;
						tc_q        <= req.target_col;
						tr_q        <= req.target_row;
						cols_q      <= req_cols;
						rows_q      <= req_rows;
						dx_q        <= '0;
						dy_q        <= '0;
						res_ok_q    <= 1'b0;
						res_cidx_q  <= 8'd0;
						res_freed_q <= 8'd0;
						res_st_q    <= gar_pkg::ST_BAD_SIZE;
						state_q     <= S_DONE;
						case (req.opcode)
							gar_pkg::OP_PLACE: begin
								if (!req_size_bad) begin
									cx_q    <= '0;
									cy_q    <= '0;
									keep_q  <= 8'd0;
									state_q <= S_CORNER;
								end
							end
							gar_pkg::OP_REMOVE: begin
								if (req_rm_in) begin
									state_q <= S_RM_RD;
								end else begin
									res_st_q <= gar_pkg::ST_NO_ROOM;
								end
							end
							gar_pkg::OP_MOVE: begin
								if (!req_size_bad) begin
									if (req_mv_fit) begin
										cx_q    <= XW'(req.target_col);
										cy_q    <= YW'(req.target_row);
										keep_q  <= req.item_id;
										state_q <= S_RD;
									end else begin
										res_st_q <= gar_pkg::ST_NO_ROOM;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_CORNER: begin
					// skip corners whose rectangle leaves the grid
					dx_q <= '0;
					dy_q <= '0;
					if ((CW'(cx_q) + CW'(w_q) <= cols_q) && (CW'(cy_q) + CW'(h_q) <= rows_q)) begin
						state_q <= S_RD;
					end else begin
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					state_q <= S_CORNER;
					if (cx_next < cols_q) begin
						cx_q <= cx_next[XW-1:0];
					end else begin
						cx_q <= '0;
						if (CW'(cy_q) + CW'(1) < rows_q) begin
							cy_q <= cy_q + YW'(1);
						end else begin
							res_st_q <= gar_pkg::ST_NO_ROOM;
							state_q  <= S_DONE;
						end
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (tile_bad) begin
						if (op_q == gar_pkg::OP_PLACE) begin
							state_q <= S_ADV;
						end else begin
							res_st_q <= gar_pkg::ST_OCCUPIED;
							state_q  <= S_DONE;
						end
					end else if (!dx_last) begin
						dx_q    <= dx_q + 5'd1;
						state_q <= S_RD;
					end else if (!dy_last) begin
						dx_q    <= '0;
						dy_q    <= dy_q + 5'd1;
						state_q <= S_RD;
					end else begin
						// rectangle is good: free the mover's old tiles first
						dx_q <= '0;
						dy_q <= '0;
						if (op_q == gar_pkg::OP_MOVE) begin
							owner_q  <= id_q;
							sw_q     <= '0;
							sw_run_q <= 1'b1;
							pend_s1  <= 1'b0;
							state_q  <= S_SWEEP;
						end else begin
							state_q <= S_CLAIM;
						end
					end
				end
				S_CLAIM: begin
					if (!dx_last) begin
						dx_q <= dx_q + 5'd1;
					end else if (!dy_last) begin
						dx_q <= '0;
						dy_q <= dy_q + 5'd1;
					end else begin
						res_ok_q   <= 1'b1;
						res_st_q   <= gar_pkg::ST_OK;
						res_cidx_q <= cidx_full[7:0];
						state_q    <= S_DONE;
					end
				end
				S_RM_RD: begin
					state_q <= S_RM_EV;
				end
				S_RM_EV: begin
					if (ram_rdata == 8'd0) begin
						res_st_q <= gar_pkg::ST_TILE_FREE;
						state_q  <= S_DONE;
					end else begin
						owner_q     <= ram_rdata;
						res_freed_q <= ram_rdata;
						sw_q        <= '0;
						sw_run_q    <= 1'b1;
						pend_s1     <= 1'b0;
						state_q     <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					// read one entry a cycle, clear the previous one on a match
					pend_s1 <= sw_run_q;
					addr_s1 <= sw_q;
					if (sw_run_q) begin
						if (sw_q == LAST_ADDR) begin
							sw_run_q <= 1'b0;
						end else begin
							sw_q <= sw_q + AW'(1);
						end
					end else if (pend_s1) begin
						if (op_q == gar_pkg::OP_MOVE) begin
							state_q <= S_CLAIM;
						end else begin
							res_ok_q <= 1'b1;
							res_st_q <= gar_pkg::ST_OK;
							state_q  <= S_DONE;
						end
					end
				end
				S_DONE: begin
					// hold until the response register is free
					if (!out_vld_q || rsp.ready) begin
						out_vld_q   <= 1'b1;
						out_ok_q    <= res_ok_q;
						out_st_q    <= res_st_q;
						out_cidx_q  <= res_cidx_q;
						out_freed_q <= res_freed_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.success       = out_ok_q;
	assign rsp.status        = out_st_q;
	assign rsp.control_index = out_cidx_q;
	assign rsp.freed_owner   = out_freed_q;

	`GAR_ASSERT(a_no_write_idle, (state_q == S_IDLE) |-> !ram_we, "store written while idle")
	`GAR_ASSERT(a_ok_matches, rsp.valid |-> (rsp.success == (rsp.status == gar_pkg::ST_OK)), "success disagrees with status")
	`GAR_ASSERT_NEXT(a_done_emits, (state_q == S_DONE) && (!out_vld_q || rsp.ready), rsp.valid && (state_q == S_IDLE), "finished item not presented")
	`GAR_ASSERT(a_claim_owner, (state_q == S_CLAIM) |-> (id_q != 8'd0), "claiming with owner zero")

endmodule
